// File: hw/rtl/ihq_pkg.sv
// Shared types and constants for the indexed max-heap queue.
package ihq_pkg;

  localparam int HEAP_SLOTS   = 1024;
  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = $clog2(HEAP_SLOTS);
  localparam int VTX_W        = $clog2(VERTEX_COUNT);
  localparam int KEY_W        = 32;
  localparam int MAP_W        = IDX_W + 1;
  localparam int ENTRY_W      = KEY_W + VTX_W;

  localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(HEAP_SLOTS - 1);

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELMAX  = 3'd1,
    OP_CHGKEY  = 3'd2,
    OP_DELAT   = 3'd3,
    OP_FIND    = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_APPEND  = 3'd6,
    OP_BUILD   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [VTX_W-1:0]        vertex_id;
    logic signed [KEY_W-1:0] key_value;
    logic [IDX_W-1:0]        heap_position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [VTX_W-1:0]        top_vertex;
    logic signed [KEY_W-1:0] top_key;
    logic [IDX_W-1:0]        entry_count;
    logic [IDX_W-1:0]        found_position;
  } out_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VTX_W-1:0]        vtx;
  } entry_t;

  typedef struct packed {
    logic             present;
    logic [IDX_W-1:0] slot;
  } map_t;

endpackage

// File: hw/rtl/indexed_max_heap_queue_core.sv
// Top level of the indexed max-heap queue: sequencer, slot and map memories.
//
// The block keeps a binary max-heap of (vertex, key) entries in a slot memory
// and a vertex-to-slot map in a second memory. One input word carries an
// operation (insert, delete max, change key, delete at, find, clear, append,
// build) and produces exactly one output word with a status, the top entry
// (or the removed one for delete max), the entry count and a found slot.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low. The block raises in_stall while it works
// on a word and takes one word at a time.
// A sift-down and a sift-up walk the tree one level at a time, and each
// operation adds setup steps and a readback of the top entry; a delete at
// sifts both ways. Build runs one sift-down per inner node. The single
// read port of the slot memory sets the pace of these walks. Clear sweeps
// the map memory, one entry a cycle, all 1024 entries. After reset the
// same sweep runs before the first word is taken.
// When the receiver stalls, the finished word waits in the output register
// and the block may already accept and work on the next input word.
module indexed_max_heap_queue_core
  import ihq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RM_A, S_RM_B, S_RM_C,
    S_CHG, S_DN_RD, S_DN_L, S_DN_R, S_DN_DEC, S_DN_END,
    S_UP_LD, S_UP_LD2, S_UP_RD, S_UP_CMP, S_UP_END,
    S_BUILD, S_BLD_LD, S_FIND, S_TOP, S_TOP2, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PICK_NONE, PICK_LEFT, PICK_RIGHT
  } pick_t;

  state_t            state;
  in_word_t          req;
  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  idx;
  entry_t            cur;
  logic              moved;
  pick_t             pick;
  entry_t            best;
  logic [2:0]        status;
  logic [IDX_W-1:0]  found;
  entry_t            top;
  logic              removed;
  logic [VTX_W-1:0]  clr_idx;
  logic              clr_reply;
  logic [IDX_W-1:0]  build_i;
  logic [VTX_W-1:0]  rm_vtx;

  // Memory ports.
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr;
  entry_t            s_wdata;
  logic [IDX_W-1:0]  s_raddr;
  entry_t            s_rdata;
  logic              m_we;
  logic [VTX_W-1:0]  m_waddr;
  map_t              m_wdata;
  logic [VTX_W-1:0]  m_raddr;
  map_t              m_rdata;

  // Tree arithmetic around the cursor.
  logic [IDX_W:0]    left_idx;
  logic [IDX_W:0]    right_idx;
  logic [IDX_W-1:0]  parent_idx;
  logic [IDX_W-1:0]  pos_sel;
  logic [IDX_W-1:0]  last_idx;

  // Shared comparator operands.
  logic signed [KEY_W-1:0] cmp_a;
  logic signed [KEY_W-1:0] cmp_b;
  logic                    cmp_less;

  assign left_idx   = {idx, 1'b1};
  assign right_idx  = {idx, 1'b0} + (IDX_W+1)'(2);
  assign parent_idx = (idx - IDX_W'(1)) >> 1;
  assign pos_sel    = (req.opcode == OP_DELMAX) ? '0 : req.heap_position;
  assign last_idx   = fill - IDX_W'(1);

  ihq_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  ihq_ram #(.WIDTH(MAP_W), .DEPTH(VERTEX_COUNT)) u_map_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // The change-key step compares the new key against the stored one; every
  // other step compares the word just read against the held entry (the right-child step against the best entry so far).
  assign cmp_a = (state == S_CHG) ? req.key_value : s_rdata.key;
  always_comb begin
    case (state)
      S_CHG:   cmp_b = s_rdata.key;
      S_DN_R:  cmp_b = best.key;
      default: cmp_b = cur.key;
    endcase
  end

  ihq_key_cmp u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .less (cmp_less)
  );

  assign in_stall = (state != S_IDLE);

  // Memory port control for each sequencer step.
  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx;
    s_wdata = cur;
    s_raddr = idx;
    m_we    = 1'b0;
    m_waddr = cur.vtx;
    m_wdata = '{present: 1'b1, slot: idx};
    m_raddr = req.vertex_id;
    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_idx;
        m_wdata = '0;
      end
      S_DISPATCH: begin
        s_raddr = pos_sel;
        if ((req.opcode == OP_INSERT || req.opcode == OP_APPEND) && fill != SLOT_MAX) begin
          s_we    = 1'b1;
          s_waddr = fill;
          s_wdata = '{key: req.key_value, vtx: req.vertex_id};
          m_we    = 1'b1;
          m_waddr = req.vertex_id;
          m_wdata = '{present: 1'b1, slot: fill};
        end
      end
      S_RM_A: begin
        s_raddr = last_idx;
        m_raddr = s_rdata.vtx;
      end
      S_RM_B: begin
        if (m_rdata == map_t'{present: 1'b1, slot: pos_sel}) begin
          m_we    = 1'b1;
          m_waddr = rm_vtx;
          m_wdata = '0;
        end
        if (pos_sel != last_idx) begin
          s_we    = 1'b1;
          s_waddr = pos_sel;
          s_wdata = s_rdata;
        end
      end
      S_RM_C: begin
        m_we    = 1'b1;
        m_waddr = cur.vtx;
        m_wdata = '{present: 1'b1, slot: pos_sel};
      end
      S_DN_RD: s_raddr = left_idx[IDX_W-1:0];
      S_DN_L:  s_raddr = right_idx[IDX_W-1:0];
      S_DN_DEC: begin
        if (pick != PICK_NONE) begin
          s_we    = 1'b1;
          s_wdata = best;
          m_we    = 1'b1;
          m_waddr = best.vtx;
        end
      end
      S_DN_END, S_UP_END: begin
        s_we = 1'b1;
        m_we = moved;
      end
      S_UP_LD: s_raddr = pos_sel;
      S_UP_RD: s_raddr = parent_idx;
      S_UP_CMP: begin
        if (cmp_less) begin
          s_we    = 1'b1;
          s_wdata = s_rdata;
          m_we    = 1'b1;
          m_waddr = s_rdata.vtx;
        end
      end
      S_BUILD: s_raddr = build_i - IDX_W'(1);
      S_TOP:   s_raddr = '0;
      default: ;
    endcase
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish step reloads the output register itself.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + VTX_W'(1);
          if (clr_idx == '1) begin
            state <= clr_reply ? S_TOP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req     <= in_data;
            status  <= ST_OK;
            found   <= '0;
            removed <= 1'b0;
            top     <= '0;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          moved <= 1'b0;
          case (req.opcode)
            OP_INSERT, OP_APPEND: begin
              if (fill == SLOT_MAX) begin
                status <= ST_FULL;
                state  <= S_TOP;
              end else begin
                cur   <= '{key: req.key_value, vtx: req.vertex_id};
                idx   <= fill;
                fill  <= fill + IDX_W'(1);
                state <= (req.opcode == OP_INSERT) ? S_UP_RD : S_TOP;
              end
            end
            OP_DELMAX: begin
              if (fill == '0) begin
                status <= ST_EMPTY;
                state  <= S_TOP;
              end else begin
                state <= S_RM_A;
              end
            end
            OP_CHGKEY, OP_DELAT: begin
              if (req.heap_position >= fill) begin
                status <= ST_BADPOS;
                state  <= S_TOP;
              end else begin
                state <= (req.opcode == OP_CHGKEY) ? S_CHG : S_RM_A;
              end
            end
            OP_FIND: state <= S_FIND;
            OP_CLEAR: begin
              fill      <= '0;
              clr_idx   <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end
            default: begin
              build_i <= fill >> 1;
              state   <= S_BUILD;
            end
          endcase
        end
        S_RM_A: begin
          rm_vtx <= s_rdata.vtx;
          if (req.opcode == OP_DELMAX) begin
            top     <= s_rdata;
            removed <= 1'b1;
          end
          state <= S_RM_B;
        end
        S_RM_B: begin
          cur   <= s_rdata;
          fill  <= last_idx;
          state <= (pos_sel != last_idx) ? S_RM_C : S_TOP;
        end
        S_RM_C: begin
          idx   <= pos_sel;
          moved <= 1'b0;
          state <= S_DN_RD;
        end
        S_CHG: begin
          cur   <= '{key: req.key_value, vtx: s_rdata.vtx};
          idx   <= req.heap_position;
          state <= cmp_less ? S_DN_RD : S_UP_RD;
        end
        S_DN_RD: begin
          state <= (left_idx >= {1'b0, fill}) ? S_DN_END : S_DN_L;
        end
        S_DN_L: begin
          // Left child wins when its key is not below the held key.
          if (!cmp_less) begin
            pick <= PICK_LEFT;
            best <= s_rdata;
          end else begin
            pick <= PICK_NONE;
            best <= cur;
          end
          state <= (right_idx < {1'b0, fill}) ? S_DN_R : S_DN_DEC;
        end
        S_DN_R: begin
          if (!cmp_less) begin
            pick <= PICK_RIGHT;
            best <= s_rdata;
          end
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (pick == PICK_NONE) begin
            state <= S_DN_END;
          end else begin
            idx   <= (pick == PICK_RIGHT) ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
            moved <= 1'b1;
            state <= S_DN_RD;
          end
        end
        S_DN_END: begin
          if (req.opcode == OP_BUILD) begin
            state <= S_BUILD;
          end else if (req.opcode == OP_DELAT) begin
            state <= S_UP_LD;
          end else begin
            state <= S_TOP;
          end
        end
        S_UP_LD: state <= S_UP_LD2;
        S_UP_LD2: begin
          cur   <= s_rdata;
          idx   <= pos_sel;
          moved <= 1'b0;
          state <= S_UP_RD;
        end
        S_UP_RD: begin
          state <= (idx == '0 || idx >= fill) ? S_UP_END : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp_less) begin
            idx   <= parent_idx;
            moved <= 1'b1;
            state <= S_UP_RD;
          end else begin
            state <= S_UP_END;
          end
        end
        S_UP_END: state <= S_TOP;
        S_BUILD: begin
          if (build_i == '0) begin
            state <= S_TOP;
          end else begin
            build_i <= build_i - IDX_W'(1);
            idx     <= build_i - IDX_W'(1);
            state   <= S_BLD_LD;
          end
        end
        S_BLD_LD: begin
          cur   <= s_rdata;
          moved <= 1'b0;
          state <= S_DN_RD;
        end
        S_FIND: begin
          if (m_rdata.present && m_rdata.slot < fill) begin
            found <= m_rdata.slot;
          end else begin
            status <= ST_NOTFOUND;
          end
          state <= S_TOP;
        end
        S_TOP: state <= S_TOP2;
        S_TOP2: begin
          if (!removed) begin
            top <= (fill != '0) ? s_rdata : '0;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_data.status         <= status;
            out_data.top_vertex     <= top.vtx;
            out_data.top_key        <= top.key;
            out_data.entry_count    <= fill;
            out_data.found_position <= found;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Once a word is taken, the block is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous word still in work");

  // A full report only comes from a heap holding its maximum entry count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.entry_count == SLOT_MAX))
    else $error("full status with a non-full heap");

  // An empty report carries no entries and a zero top entry.
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.entry_count == '0 && out_data.top_key == '0 && out_data.top_vertex == '0))
    else $error("empty status with entries or a top entry");

  // A sift-down move always lands inside the live part of the heap.
  a_sift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_DEC) |-> (idx < fill))
    else $error("sift-down cursor outside the heap");

endmodule

// File: hw/rtl/ihq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ihq_key_cmp.sv
// Shared signed key comparator used by every sift and key-change step.
module ihq_key_cmp
  import ihq_pkg::*;
(
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output logic                    less
);

  assign less = (a < b);

endmodule
